@@ rtl/core/llr_pkg.sv @@
// shared types and constants of the log ring line reader
package llr_pkg;

	localparam int unsigned RING_BYTES = 65536;
	localparam int unsigned ADDR_W     = $clog2(RING_BYTES);
	localparam int unsigned FILL_W     = ADDR_W + 1;

	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_BYTES);

	localparam int unsigned COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int unsigned CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic [CAP_W-1:0] CAP_LIMIT = 7'd64;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  byte_value;
		logic [15:0] line_index;
	} llr_cmd_t;

endpackage

@@ rtl/core/llr_ram.sv @@
// generic simple dual port ram with registered read
module llr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// data holds while rd_en is low
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/llr_front.sv @@
// front end: accepts items, drops unused codes, queues commands for the back end
module llr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	output logic              cmd_valid,
	output llr_pkg::llr_cmd_t cmd,
	input  logic              cmd_pop
);

	llr_pkg::llr_cmd_t                 queue_q [llr_pkg::QUEUE_DEPTH];
	logic [llr_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [llr_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [llr_pkg::QPTR_W:0]          level_q;
	logic                              push;
	logic                              pop;
	logic                              known_op;

	// code 3 is accepted and dropped
	assign known_op = s_tuser inside {llr_pkg::OP_WRITE, llr_pkg::OP_COUNT, llr_pkg::OP_READ};

	assign s_tready  = (level_q != (llr_pkg::QPTR_W+1)'(llr_pkg::QUEUE_DEPTH));
	assign push      = s_tvalid && s_tready && known_op;
	assign cmd_valid = (level_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{operation: s_tuser, byte_value: s_tdata[7:0],
				line_index: s_tdata[23:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ rtl/core/llr_back.sv @@
// back end: ring writes, window scans and the result register
module llr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  llr_pkg::llr_cmd_t          cmd,
	output logic                       cmd_pop,
	input  logic [llr_pkg::CAP_W-1:0]  line_capacity,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [31:0]                m_tdata,
	output logic [1:0]                 m_tuser,
	output logic                       m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TERM = 2'd2;

	localparam int unsigned AW = llr_pkg::ADDR_W;
	localparam int unsigned FW = llr_pkg::FILL_W;
	localparam int unsigned CW = llr_pkg::COUNT_W;

	logic [1:0]                state_q;
	logic [AW-1:0]             head_q;
	logic [FW-1:0]             fill_q;
	logic                      is_read_q;
	logic [AW-1:0]             start_q;
	logic [FW-1:0]             span_q;
	logic [FW-1:0]             issued_q;
	logic                      data_v_q;
	logic [15:0]               want_q;
	logic [llr_pkg::CAP_W-1:0] cap_q;
	logic                      in_line_q;
	logic [15:0]               line_q;
	logic [llr_pkg::CAP_W-1:0] len_q;
	logic                      hit_q;
	logic [CW-1:0]             lines_q;

	logic                      out_v_q;
	logic [7:0]                out_char_q;
	logic                      out_cv_q;
	logic                      out_found_q;
	logic [CW-1:0]             out_cnt_q;
	logic                      out_last_q;

	logic [7:0]                rd_byte;
	logic                      ram_we;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic                      out_blocked;
	logic                      out_load;
	logic                      is_nl;
	logic                      want_match;
	logic                      room;
	logic                      emit;
	logic                      advance;
	logic                      take_byte;
	logic                      scan_done;
	logic [llr_pkg::CAP_W-1:0] cap_eff;

	llr_ram #(.WIDTH(8), .DEPTH(llr_pkg::RING_BYTES)) u_ring (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (head_q),
		.wr_data (cmd.byte_value),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (rd_byte)
	);

	assign cap_eff = (line_capacity > llr_pkg::CAP_LIMIT) ? llr_pkg::CAP_LIMIT : line_capacity;

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign ram_we  = cmd_pop && (cmd.operation == llr_pkg::OP_WRITE);

	assign out_blocked = out_v_q && !m_tready;
	assign is_nl       = (rd_byte == llr_pkg::NEWLINE_BYTE);
	assign want_match  = (line_q == want_q);
	assign room        = ({1'b0, len_q} + 8'd1) < {1'b0, cap_q};
	assign emit        = (state_q == ST_SCAN) && data_v_q && !hit_q && is_read_q &&
		!is_nl && want_match && room;
	// a character that finds the result register full holds the scan
	assign advance     = !(emit && out_blocked);
	assign take_byte   = (state_q == ST_SCAN) && data_v_q && advance && !hit_q;
	assign ram_re      = (state_q == ST_SCAN) && advance && !hit_q && (issued_q != span_q);
	assign ram_raddr   = start_q + issued_q[AW-1:0];
	assign scan_done   = (state_q == ST_SCAN) &&
		(hit_q || ((issued_q == span_q) && !data_v_q));
	// a character or the terminating item enters the result register
	assign out_load    = (emit || (state_q == ST_TERM)) && !out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			data_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			is_read_q <= 1'b0;
			issued_q  <= '0;
			span_q    <= '0;
			hit_q     <= 1'b0;
			in_line_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.operation == llr_pkg::OP_WRITE) begin
							head_q <= head_q + 1'b1;
							if (fill_q != llr_pkg::FILL_MAX) begin
								fill_q <= fill_q + 1'b1;
							end
						end else begin
							is_read_q <= (cmd.operation == llr_pkg::OP_READ);
							issued_q  <= '0;
							span_q    <= fill_q;
							hit_q     <= 1'b0;
							in_line_q <= 1'b0;
							data_v_q  <= 1'b0;
							if ((cmd.operation == llr_pkg::OP_READ) && (cap_eff == '0)) begin
								state_q <= ST_TERM;
							end else begin
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						data_v_q <= 1'b0;
						state_q  <= ST_TERM;
					end else if (advance) begin
						data_v_q <= ram_re;
						if (ram_re) begin
							issued_q <= issued_q + 1'b1;
						end
					end
					if (take_byte && is_read_q) begin
						if (is_nl) begin
							if (in_line_q && want_match) begin
								hit_q <= 1'b1;
							end
							in_line_q <= 1'b0;
						end else begin
							in_line_q <= 1'b1;
						end
					end
				end
				ST_TERM: begin
					if (!out_blocked) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.operation != llr_pkg::OP_WRITE)) begin
			start_q <= head_q - fill_q[AW-1:0];
			want_q  <= cmd.line_index;
			cap_q   <= cap_eff;
			line_q  <= '0;
			len_q   <= '0;
			lines_q <= '0;
		end
		if (take_byte) begin
			if (is_read_q) begin
				if (is_nl && in_line_q && !want_match) begin
					line_q <= line_q + 1'b1;
				end
				if (emit) begin
					len_q <= len_q + 1'b1;
				end
			end else if (is_nl && (lines_q != llr_pkg::COUNT_MAX)) begin
				lines_q <= lines_q + 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit && !out_blocked) begin
			out_char_q  <= rd_byte;
			out_cv_q    <= 1'b1;
			out_found_q <= 1'b0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
		end else if ((state_q == ST_TERM) && !out_blocked) begin
			out_char_q  <= '0;
			out_cv_q    <= 1'b0;
			out_found_q <= is_read_q && (hit_q || (in_line_q && want_match));
			out_cnt_q   <= is_read_q ? '0 : lines_q;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, out_cnt_q, out_char_q};
	assign m_tuser  = {out_found_q, out_cv_q};
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/core/log_ring_line_reader.sv @@
// top level of the log ring line reader
//
// input channel s_*: one item per handshake; tuser carries the operation
// (write byte, count newlines, read line), tdata the byte and line index
// output channel m_*: result items; tlast marks the final item of an operation
// configuration: cfg_wr_en writes line_capacity; the user must write it
// only while the block is idle, which the block itself does not enforce
// writes: one item per cycle while no scan runs; the front queue holds four
// commands and the back end retires one write per cycle into the ring ram
// count: one result item; the scan reads one ring byte per cycle through the
// single read port of the ring ram
// read line: the characters of the line stream out while the scan runs, then
// one terminating item with found; the scan stops at the end of the line
// a receiver stall holds the result register, and a character that meets a
// full register pauses the scan until it drains; new items queue meanwhile
// reset: head and fill count cleared, line_capacity back to 64; ring contents
// are left as they are, since only written bytes inside the window are read
module log_ring_line_reader (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // byte_value [7:0], line_index [23:8]
	input  logic [1:0]  s_tuser,   // operation [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // char_value [7:0], line_count [24:8], zero pad
	output logic [1:0]  m_tuser,   // char_valid [0], found [1]
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data
);

	logic [llr_pkg::CAP_W-1:0] line_capacity_q;
	logic                      cmd_valid;
	logic                      cmd_pop;
	llr_pkg::llr_cmd_t         cmd;

	// capacity register, raw value kept; clamping to 64 happens in the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_capacity_q <= llr_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			line_capacity_q <= cfg_wr_data;
		end
	end

	// front: accept and classify
	llr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: ring, scans and results
	llr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.line_capacity (line_capacity_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

	// a character item never closes an operation
	a_char_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast)
		else $error("character item marked last");

	// found only appears on the terminating item
	a_found_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("found outside terminating item");

	// character and found results carry no line count
	a_char_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != 2'b00) |-> (m_tdata[31:8] == 24'd0))
		else $error("line count on read result");

endmodule
